// ----- src/diff_pressure_frame_convert_assert.svh -----
// Assertion macros for the pressure frame converter.
// Clock aclk and active-low reset aresetn are taken from the including scope.
`ifndef DIFF_PRESSURE_FRAME_CONVERT_ASSERT_SVH
`define DIFF_PRESSURE_FRAME_CONVERT_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define DPFC_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define DPFC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/dpfc_pkg.sv -----
// Shared types and constants for the pressure frame converter.
// No dependencies; used by every module of the block.
package dpfc_pkg;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_BUS_ERR  = 2'd1,
        ST_MEAS_ERR = 2'd2,
        ST_DISABLED = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_OFFSET     = 2'd1;
    localparam logic [1:0] CFG_FULL_SCALE = 2'd2;

    localparam logic [14:0] FULL_SCALE_RESET = 15'd256;

    localparam logic [13:0] PRESS_RAIL = 14'h3FFF;
    localparam logic [10:0] TEMP_RAIL  = 11'h7FF;
    localparam int          DIFF_LIMIT = 255;
    localparam logic [15:0] PRESS_MID  = 16'd16383;

    // Pressure: FS * 6894757 * |16383 - S| / (512 * 409575), rounded
    localparam logic [22:0] PSI_K      = 23'd6894757;
    localparam logic [26:0] HALF_DEN   = 27'd104851200;
    localparam int          DEN_SHIFT  = 9;
    localparam logic [18:0] DEN_ODD    = 19'd409575;
    localparam logic [24:0] RECIP_P    = 25'd21476147;  // floor(2^43 / 409575)
    localparam int          RECIP_P_SH = 43;

    // Temperature: (128000 * T + bias) / 10235
    localparam logic [16:0] TEMP_GAIN  = 17'd128000;
    localparam logic [29:0] TEMP_BIAS  = 30'd584693821;
    localparam logic [13:0] TEMP_DEN   = 14'd10235;
    localparam logic [17:0] RECIP_T    = 18'd209817;    // floor(2^31 / 10235)

    localparam logic signed [26:0] P_MAX = 27'sd16777215;
    localparam logic signed [26:0] P_MIN = -27'sd16777216;

    typedef struct packed {
        logic [1:0]  hdr;
        logic [13:0] press;
        logic [10:0] temp;
        logic        rail;
    } lane_t;

    typedef struct packed {
        status_t     status;
        logic        neg;
        logic [13:0] mag;
        logic [11:0] tsum;
    } merge_t;

endpackage

// ----- src/dpfc_lane.sv -----
// One frame lane: unpack the counts of a 4-byte frame and flag rail values.
// Depends on dpfc_pkg.
module dpfc_lane (
    input  logic [31:0]          frame,
    output dpfc_pkg::lane_t      lane
);

    always_comb begin
        lane.hdr   = frame[31:30];
        lane.press = frame[29:16];
        lane.temp  = frame[15:5];
        lane.rail  = (lane.press == '0) || (lane.press == dpfc_pkg::PRESS_RAIL) ||
                     (lane.temp == '0)  || (lane.temp == dpfc_pkg::TEMP_RAIL);
    end

endmodule

// ----- src/dpfc_merge.sv -----
// Merge of the two frame lanes: status precedence, agreement check and sums.
// Depends on dpfc_pkg.
module dpfc_merge (
    input  logic                 enable,
    input  logic                 first_ok,
    input  logic                 second_ok,
    input  dpfc_pkg::lane_t      lane_a,
    input  dpfc_pkg::lane_t      lane_b,
    output dpfc_pkg::merge_t     merged
);

    logic signed [14:0] dp;
    logic signed [11:0] dt;
    logic [14:0]        psum;
    logic signed [15:0] mid_diff;
    logic               disagree;

    always_comb begin
        dp       = $signed({1'b0, lane_a.press}) - $signed({1'b0, lane_b.press});
        dt       = $signed({1'b0, lane_a.temp}) - $signed({1'b0, lane_b.temp});
        disagree = (dp > 15'sd255) || (dp < -15'sd255) ||
                   (dt > 12'sd255) || (dt < -12'sd255);
        psum     = 15'(lane_a.press) + 15'(lane_b.press);
        mid_diff = $signed(dpfc_pkg::PRESS_MID) - $signed({1'b0, psum});

        merged.neg  = mid_diff[15];
        merged.mag  = mid_diff[15] ? 14'(-mid_diff) : mid_diff[13:0];
        merged.tsum = 12'(lane_a.temp) + 12'(lane_b.temp);

        if (!enable) begin
            merged.status = dpfc_pkg::ST_DISABLED;
        end else if (!first_ok || !second_ok || lane_a.hdr[1]) begin
            merged.status = dpfc_pkg::ST_BUS_ERR;
        end else if (lane_a.rail || lane_b.rail || disagree) begin
            merged.status = dpfc_pkg::ST_MEAS_ERR;
        end else begin
            merged.status = dpfc_pkg::ST_VALID;
        end
    end

endmodule

// ----- src/diff_pressure_frame_convert.sv -----
// Top level of the differential pressure frame converter.
// Depends on dpfc_pkg, dpfc_lane, dpfc_merge and the assertion macro header.
//
// Usage:
//   s_* channel: one item = two 32-bit sensor frames plus a read-ok flag each.
//   m_* channel: one result per item = status, pressure (1/16 Pa, saturated)
//   and temperature (1/256 K). Fields are zero unless status is valid.
//   cfg_*: write-only registers (enable, pressure offset, full scale), taken
//   on any edge with cfg_we high; change them only while the block is idle.
// Pipeline: two lanes unpack and check the frames as the item is accepted
//   into stage 0, seven arithmetic stages run the products and the
//   reciprocal-multiply divisions (pressure by 209702400, temperature by
//   10235, each with a one-step correction), then the output register
//   loads and m_valid rises.
// Throughput: one item per cycle unless stalled; each stage has a valid bit.
// Stall: each stage holds when it is full and the stage after it holds, so
//   items fill bubbles and s_ready drops only once the pipeline is full
//   behind a stalled m_ready. Results are never dropped or repeated.
// Reset: aresetn (synchronous, active low) empties the pipeline and sets
//   enable 0, offset 0, full scale 256/256 psi.
module diff_pressure_frame_convert (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [17:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [31:0]         s_first_frame,
    input  logic [31:0]         s_second_frame,
    input  logic                s_first_read_ok,
    input  logic                s_second_read_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_result_status,
    output logic signed [24:0]  m_pressure_sixteenth_pa,
    output logic [16:0]         m_temperature_k_q8
);

    `include "diff_pressure_frame_convert_assert.svh"

    // ---------------- configuration registers ----------------
    logic        enable_reg;
    logic [17:0] offset_reg;
    logic [14:0] full_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            offset_reg     <= '0;
            full_scale_reg <= dpfc_pkg::FULL_SCALE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                dpfc_pkg::CFG_ENABLE:     enable_reg     <= cfg_wdata[0];
                dpfc_pkg::CFG_OFFSET:     offset_reg     <= cfg_wdata;
                dpfc_pkg::CFG_FULL_SCALE: full_scale_reg <= cfg_wdata[14:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---------------- frame lanes and merge ----------------
    dpfc_pkg::lane_t  lane_a, lane_b;
    dpfc_pkg::merge_t merged;

    dpfc_lane u_lane_a (.frame(s_first_frame),  .lane(lane_a));
    dpfc_lane u_lane_b (.frame(s_second_frame), .lane(lane_b));

    dpfc_merge u_merge (
        .enable    (enable_reg),
        .first_ok  (s_first_read_ok),
        .second_ok (s_second_read_ok),
        .lane_a    (lane_a),
        .lane_b    (lane_b),
        .merged    (merged)
    );

    // ---------------- pipeline flow control ----------------
    // Stages 0..7 are internal; stage 8 is the output register.
    logic [7:0] valid_reg;
    logic       m_valid_reg;
    logic [8:0] st_en;

    always_comb begin
        st_en[8] = !m_valid_reg || m_ready;
        for (int i = 7; i >= 0; i--) begin
            st_en[i] = !valid_reg[i] || st_en[i + 1];
        end
    end

    assign s_ready = st_en[0];
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (st_en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < 8; i++) begin
                if (st_en[i]) begin
                    valid_reg[i] <= valid_reg[i - 1];
                end
            end
            if (st_en[8]) begin
                m_valid_reg <= valid_reg[7];
            end
        end
    end

    // Status and sign ride along with the data of every stage.
    dpfc_pkg::status_t stat_reg [8];
    logic [7:0]        neg_reg;

    always_ff @(posedge aclk) begin
        if (st_en[0]) begin
            stat_reg[0] <= merged.status;
            neg_reg[0]  <= merged.neg;
        end
        for (int i = 1; i < 8; i++) begin
            if (st_en[i]) begin
                stat_reg[i] <= stat_reg[i - 1];
                neg_reg[i]  <= neg_reg[i - 1];
            end
        end
    end

    // ---------------- arithmetic payload ----------------
    logic [13:0] mag0_reg;
    logic [11:0] tsum0_reg;
    logic [28:0] fsm1_reg;      // full scale * |16383 - S|
    logic [30:0] nt1_reg;       // temperature numerator
    logic [51:0] m2_reg;        // pressure numerator magnitude
    logic [30:0] nt2_reg;
    logic [16:0] qte2_reg;      // temperature quotient estimate
    logic [42:0] np3_reg;       // pressure numerator >> 9, rounding added
    logic [30:0] nt3_reg;
    logic [16:0] qte3_reg;
    logic [30:0] qtp3_reg;
    logic [45:0] ph4_reg;
    logic [46:0] pl4_reg;
    logic [42:0] np4_reg;
    logic [16:0] tq4_reg;
    logic [24:0] qpe5_reg;      // pressure quotient estimate
    logic [42:0] np5_reg;
    logic [16:0] tq5_reg;
    logic [43:0] pqp6_reg;
    logic [24:0] qpe6_reg;
    logic [42:0] np6_reg;
    logic [16:0] tq6_reg;
    logic [24:0] q7_reg;
    logic [16:0] tq7_reg;

    logic [48:0] tprod;
    logic [67:0] psum5;
    logic [30:0] trem;
    logic [43:0] prem;

    always_comb begin
        tprod = 49'(nt1_reg) * 49'(dpfc_pkg::RECIP_T);
        trem  = nt3_reg - qtp3_reg;
        psum5 = {ph4_reg, 22'b0} + 68'(pl4_reg);
        prem  = 44'(np6_reg) - pqp6_reg;
    end

    always_ff @(posedge aclk) begin
        if (st_en[0]) begin
            mag0_reg  <= merged.mag;
            tsum0_reg <= merged.tsum;
        end
        if (st_en[1]) begin
            fsm1_reg <= 29'(full_scale_reg) * 29'(mag0_reg);
            nt1_reg  <= 31'(tsum0_reg) * 31'(dpfc_pkg::TEMP_GAIN)
                        + 31'(dpfc_pkg::TEMP_BIAS);
        end
        if (st_en[2]) begin
            m2_reg   <= 52'(fsm1_reg) * 52'(dpfc_pkg::PSI_K);
            nt2_reg  <= nt1_reg;
            qte2_reg <= tprod[47:31];
        end
        if (st_en[3]) begin
            np3_reg  <= 43'((m2_reg + 52'(dpfc_pkg::HALF_DEN)) >> dpfc_pkg::DEN_SHIFT);
            nt3_reg  <= nt2_reg;
            qte3_reg <= qte2_reg;
            qtp3_reg <= 31'(qte2_reg) * 31'(dpfc_pkg::TEMP_DEN);
        end
        if (st_en[4]) begin
            // Split the 43-bit numerator so each product stays narrow.
            ph4_reg <= 46'(np3_reg[42:22]) * 46'(dpfc_pkg::RECIP_P);
            pl4_reg <= 47'(np3_reg[21:0]) * 47'(dpfc_pkg::RECIP_P);
            np4_reg <= np3_reg;
            tq4_reg <= (trem >= 31'(dpfc_pkg::TEMP_DEN)) ? qte3_reg + 17'd1 : qte3_reg;
        end
        if (st_en[5]) begin
            qpe5_reg <= psum5[dpfc_pkg::RECIP_P_SH +: 25];
            np5_reg  <= np4_reg;
            tq5_reg  <= tq4_reg;
        end
        if (st_en[6]) begin
            pqp6_reg <= 44'(qpe5_reg) * 44'(dpfc_pkg::DEN_ODD);
            qpe6_reg <= qpe5_reg;
            np6_reg  <= np5_reg;
            tq6_reg  <= tq5_reg;
        end
        if (st_en[7]) begin
            q7_reg  <= (prem >= 44'(dpfc_pkg::DEN_ODD)) ? qpe6_reg + 25'd1 : qpe6_reg;
            tq7_reg <= tq6_reg;
        end
    end

    // ---------------- output stage: sign, offset, saturate ----------------
    logic signed [26:0] q_signed;
    logic signed [26:0] off_scaled;
    logic signed [26:0] p_sum;
    logic signed [24:0] p_sat;

    always_comb begin
        q_signed   = neg_reg[7] ? -$signed(27'(q7_reg)) : $signed(27'(q7_reg));
        off_scaled = $signed({{5{offset_reg[17]}}, offset_reg, 4'b0000});
        p_sum      = q_signed + off_scaled;
        if (p_sum > dpfc_pkg::P_MAX) begin
            p_sat = 25'(dpfc_pkg::P_MAX);
        end else if (p_sum < dpfc_pkg::P_MIN) begin
            p_sat = 25'(dpfc_pkg::P_MIN);
        end else begin
            p_sat = p_sum[24:0];
        end
    end

    dpfc_pkg::status_t  out_stat_reg;
    logic signed [24:0] out_press_reg;
    logic [16:0]        out_temp_reg;

    always_ff @(posedge aclk) begin
        if (st_en[8]) begin
            out_stat_reg <= stat_reg[7];
            // Zero the fields of every item that did not convert.
            if (stat_reg[7] == dpfc_pkg::ST_VALID) begin
                out_press_reg <= p_sat;
                out_temp_reg  <= tq7_reg;
            end else begin
                out_press_reg <= '0;
                out_temp_reg  <= '0;
            end
        end
    end

    assign m_result_status         = out_stat_reg;
    assign m_pressure_sixteenth_pa = out_press_reg;
    assign m_temperature_k_q8      = out_temp_reg;

    // ---------------- assertions ----------------
    `DPFC_CHECK(a_fields_zero_on_error,
        m_valid_reg && (out_stat_reg != dpfc_pkg::ST_VALID),
        (out_press_reg == '0) && (out_temp_reg == '0),
        "result fields not zero on error status")
    `DPFC_CHECK(a_stall_only_from_output, !s_ready, m_valid_reg && !m_ready,
        "input stalled while output side can move")
    `DPFC_CHECK(a_press_recip_bound, valid_reg[6],
        prem < (44'(dpfc_pkg::DEN_ODD) << 1),
        "pressure quotient estimate off by more than one")
    `DPFC_CHECK(a_temp_recip_bound, valid_reg[3],
        trem < (31'(dpfc_pkg::TEMP_DEN) << 1),
        "temperature quotient estimate off by more than one")
    `DPFC_CHECK_NEXT(a_disabled_status, s_valid && s_ready && !enable_reg && !cfg_we,
        valid_reg[0] && (stat_reg[0] == dpfc_pkg::ST_DISABLED),
        "item accepted while disabled lost its status")

endmodule
